// ===== rtl/zrle_pkg.sv =====
// ----------------------------------------------------------------------------
// zrle_pkg
// Shared constants and types of the zero-RLE module image loader: header
// limits, result kinds and the result word layout.
// ----------------------------------------------------------------------------
package zrle_pkg;

    localparam int unsigned RELOC_BYTES_MAX = 1024;
    localparam int unsigned WINDOW_BYTES    = 16384;
    localparam int unsigned PREFIX_BYTES    = 16;

    // Code image header overhead and smallest legal code size
    localparam int unsigned CODE_MIN        = 32;
    localparam int unsigned CODE_MAX        = CODE_MIN + WINDOW_BYTES;
    localparam int unsigned HEADER_BYTES    = 8;

    // Output position never exceeds code size plus relocation size
    localparam int unsigned POS_W    = $clog2(CODE_MAX + RELOC_BYTES_MAX + 1);
    localparam int unsigned OFFSET_W = 15;
    localparam int unsigned LEN_W    = 9;

    localparam logic [7:0] TAG_BYTE0 = 8'h4C;   // 'L'
    localparam logic [7:0] TAG_BYTE1 = 8'h31;   // '1'

    typedef enum logic [2:0] {
        KIND_CODE = 3'd0,
        KIND_MAP  = 3'd1,
        KIND_OK   = 3'd2,
        KIND_FMT  = 3'd3,
        KIND_BIG  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [OFFSET_W-1:0] offset;
        logic [LEN_W-1:0]    run_length;
        logic [7:0]          fill_value;
        logic                last_of_item;
    } res_t;

    // Up to three result words per input byte, slot 0 first
    typedef struct packed {
        logic [1:0]      count;
        res_t [2:0]      slot;
    } dec_out_t;

endpackage

// ===== rtl/zrle_decode.sv =====
// ----------------------------------------------------------------------------
// zrle_decode
// Decoder state and the single-pass decode of one file byte into up to three
// result words. State advances when the top level commits the byte.
// ----------------------------------------------------------------------------
module zrle_decode import zrle_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] stream_byte,
    input  logic       starts_file,
    output dec_out_t   dec
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_COUNT,
        PH_IDLE
    } phase_t;

    phase_t            phase_reg, phase_next, eff_phase;
    logic [15:0]       taken_reg, taken_next, eff_taken;
    logic [POS_W-1:0]  pos_reg, pos_next, eff_pos;
    logic [15:0]       file_len_reg, file_len_next, eff_file;
    logic [15:0]       code_len_reg, code_len_next, eff_code;
    logic [15:0]       reloc_len_reg, reloc_len_next, eff_reloc;
    logic              comp_reg, comp_next, eff_comp;

    logic [16:0]       expected, remain, hdr_expected;
    logic [15:0]       reloc_new, code_room;
    logic [16:0]       pos_w;
    logic [2:0]        hdr_idx;
    logic [LEN_W-1:0]  count_n, clip_n, run_n, first_len;
    logic [7:0]        run_fill;
    logic              is_count, is_literal, do_run, in_code;
    logic [POS_W-1:0]  new_pos;
    logic [15:0]       new_taken;

    res_t              run0, run1, status;
    logic              run0_v, run1_v, status_v;

    // Restart on a file start: work from cleared state
    always_comb begin
        if (starts_file) begin
            eff_phase = PH_HEADER;
            eff_taken = '0;
            eff_pos   = '0;
            eff_file  = '0;
            eff_code  = '0;
            eff_reloc = '0;
            eff_comp  = 1'b0;
        end else begin
            eff_phase = phase_reg;
            eff_taken = taken_reg;
            eff_pos   = pos_reg;
            eff_file  = file_len_reg;
            eff_code  = code_len_reg;
            eff_reloc = reloc_len_reg;
            eff_comp  = comp_reg;
        end
    end

    // Run length and boundary split for the data phase
    always_comb begin
        pos_w      = 17'(eff_pos);
        expected   = {1'b0, eff_code} + {1'b0, eff_reloc};
        remain     = expected - pos_w;
        count_n    = (stream_byte == 8'd0) ? LEN_W'(256) : LEN_W'(stream_byte);
        clip_n     = (remain < 17'(count_n)) ? remain[LEN_W-1:0] : count_n;
        is_count   = (eff_phase == PH_COUNT);
        is_literal = !eff_comp || (eff_pos < POS_W'(PREFIX_BYTES))
                     || (stream_byte != 8'd0);
        do_run     = is_count || is_literal;
        run_n      = is_count ? clip_n : LEN_W'(1);
        run_fill   = is_count ? 8'd0 : stream_byte;
        in_code    = pos_w < {1'b0, eff_code};
        code_room  = eff_code - pos_w[15:0];
        first_len  = (code_room < 16'(run_n)) ? code_room[LEN_W-1:0] : run_n;
        new_pos    = do_run ? (eff_pos + POS_W'(run_n)) : eff_pos;
        new_taken  = eff_taken + 16'd1;
        hdr_idx    = eff_taken[2:0];
        reloc_new  = {stream_byte, eff_reloc[7:0]};
        hdr_expected = {1'b0, eff_code} + {1'b0, reloc_new};
    end

    always_comb begin
        phase_next     = eff_phase;
        taken_next     = eff_taken;
        pos_next       = eff_pos;
        file_len_next  = eff_file;
        code_len_next  = eff_code;
        reloc_len_next = eff_reloc;
        comp_next      = eff_comp;

        run0     = '0;
        run1     = '0;
        status   = '0;
        run0_v   = 1'b0;
        run1_v   = 1'b0;
        status_v = 1'b0;

        case (eff_phase)
            PH_HEADER: begin
                // Header bytes are also the first bytes of the code image
                run0_v            = 1'b1;
                run0.kind         = KIND_CODE;
                run0.offset       = OFFSET_W'(hdr_idx);
                run0.run_length   = LEN_W'(1);
                run0.fill_value   = stream_byte;
                taken_next        = 16'(hdr_idx) + 16'd1;
                pos_next          = POS_W'(hdr_idx) + POS_W'(1);
                if ((hdr_idx == 3'd0 && stream_byte != TAG_BYTE0)
                        || (hdr_idx == 3'd1 && stream_byte != TAG_BYTE1)) begin
                    status_v    = 1'b1;
                    status.kind = KIND_FMT;
                end else begin
                    case (hdr_idx)
                        3'd2: file_len_next  = {eff_file[15:8], stream_byte};
                        3'd3: file_len_next  = {stream_byte, eff_file[7:0]};
                        3'd4: code_len_next  = {eff_code[15:8], stream_byte};
                        3'd5: code_len_next  = {stream_byte, eff_code[7:0]};
                        3'd6: reloc_len_next = {eff_reloc[15:8], stream_byte};
                        3'd7: begin
                            reloc_len_next = reloc_new;
                            if (eff_file < 16'(HEADER_BYTES) || eff_code < 16'(CODE_MIN)) begin
                                status_v    = 1'b1;
                                status.kind = KIND_FMT;
                            end else if (reloc_new > 16'(RELOC_BYTES_MAX)) begin
                                status_v    = 1'b1;
                                status.kind = KIND_BIG;
                            end else if (eff_code > 16'(CODE_MAX)) begin
                                status_v    = 1'b1;
                                status.kind = KIND_FMT;
                            end else begin
                                comp_next  = (hdr_expected != {1'b0, eff_file});
                                phase_next = PH_DATA;
                                if (17'(HEADER_BYTES) >= hdr_expected) begin
                                    status_v    = 1'b1;
                                    status.kind = KIND_OK;
                                end else if (16'(HEADER_BYTES) >= eff_file) begin
                                    status_v    = 1'b1;
                                    status.kind = KIND_FMT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            PH_DATA, PH_COUNT: begin
                if (do_run) begin
                    run0_v          = 1'b1;
                    run0.fill_value = run_fill;
                    if (in_code) begin
                        run0.kind       = KIND_CODE;
                        run0.offset     = OFFSET_W'(eff_pos);
                        run0.run_length = first_len;
                        // Spill the tail of the run into the bitmap
                        run1_v          = (run_n > first_len);
                        run1.kind       = KIND_MAP;
                        run1.run_length = run_n - first_len;
                        run1.fill_value = run_fill;
                    end else begin
                        run0.kind       = KIND_MAP;
                        run0.offset     = OFFSET_W'(pos_w[15:0] - eff_code);
                        run0.run_length = run_n;
                    end
                    phase_next = PH_DATA;
                end else begin
                    phase_next = PH_COUNT;
                end
                pos_next   = new_pos;
                taken_next = new_taken;
                if (17'(new_pos) >= expected) begin
                    status_v    = 1'b1;
                    status.kind = KIND_OK;
                end else if (new_taken >= eff_file) begin
                    status_v    = 1'b1;
                    status.kind = KIND_FMT;
                end
            end
            default: ;
        endcase

        if (status_v) begin
            phase_next = PH_IDLE;
        end
        status.last_of_item = 1'b1;
    end

    // Pack the results into slots, run words ahead of the status word
    always_comb begin
        dec = '0;
        if (run0_v) begin
            dec.slot[0] = run0;
            if (run1_v) begin
                dec.slot[1] = run1;
                dec.slot[2] = status;
                dec.count   = status_v ? 2'd3 : 2'd2;
                dec.slot[1].last_of_item = !status_v;
            end else begin
                dec.slot[1] = status;
                dec.count   = status_v ? 2'd2 : 2'd1;
                dec.slot[0].last_of_item = !status_v;
            end
        end else begin
            dec.slot[0] = status;
            dec.count   = status_v ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            taken_reg     <= '0;
            pos_reg       <= '0;
            file_len_reg  <= '0;
            code_len_reg  <= '0;
            reloc_len_reg <= '0;
            comp_reg      <= 1'b0;
        end else if (advance) begin
            phase_reg     <= phase_next;
            taken_reg     <= taken_next;
            pos_reg       <= pos_next;
            file_len_reg  <= file_len_next;
            code_len_reg  <= code_len_next;
            reloc_len_reg <= reloc_len_next;
            comp_reg      <= comp_next;
        end
    end

endmodule

// ===== rtl/zero_rle_image_loader_decoder.sv =====
// ----------------------------------------------------------------------------
// zero_rle_image_loader_decoder
// Zero-RLE module file decoder: turns file bytes into code and bitmap write
// runs, closing each load with a status word.
// ----------------------------------------------------------------------------
// Feed the module file one byte per word on the s_ channel, with
// s_starts_file high on offset 0 (after reset the first byte counts as offset
// 0 anyway). Each byte yields zero to three result words on the m_ channel:
// a code or bitmap run, a bitmap tail when a run crosses the code/bitmap
// boundary, and a final ok or error status; m_last_of_item marks the last
// word of each byte. A byte passes through an input register, is decoded
// combinationally and its words land in a three-deep result register that
// drains one word per cycle while m_ready is high. Bytes that give at most one
// word stream at one per cycle with m_ready high; a byte that gives more words
// holds the input until its last word is taken, set by the single result port.
// ----------------------------------------------------------------------------
module zero_rle_image_loader_decoder import zrle_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_stream_byte,
    input  logic                s_starts_file,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_kind,
    output logic [OFFSET_W-1:0] m_offset,
    output logic [LEN_W-1:0]    m_run_length,
    output logic [7:0]          m_fill_value,
    output logic                m_last_of_item
);

    // Input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg, in_byte_next;
    logic        in_starts_reg, in_starts_next;

    // Result register: slot 0 is the word on show, later slots follow
    logic [1:0]  rem_reg, rem_next;
    res_t [2:0]  slot_reg, slot_next;

    dec_out_t    dec;
    logic        buf_free, fire, s_take, m_take;

    // Room for a new byte's words once the last waiting word goes this cycle
    assign buf_free = (rem_reg == 2'd0) || (rem_reg == 2'd1 && m_ready);
    assign fire     = in_valid_reg && buf_free;
    assign s_ready  = !in_valid_reg || fire;
    assign s_take   = s_valid && s_ready;
    assign m_take   = m_valid && m_ready;

    zrle_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (fire),
        .stream_byte (in_byte_reg),
        .starts_file (in_starts_reg),
        .dec         (dec)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        in_starts_next = in_starts_reg;
        if (s_take) begin
            in_valid_next  = 1'b1;
            in_byte_next   = s_stream_byte;
            in_starts_next = s_starts_file;
        end else if (fire) begin
            in_valid_next  = 1'b0;
        end
    end

    always_comb begin
        rem_next  = rem_reg;
        slot_next = slot_reg;
        if (fire) begin
            // Load the decoded words; a byte with no words leaves it empty
            rem_next  = dec.count;
            slot_next = dec.slot;
        end else if (m_take) begin
            // Advance the queue by one word
            rem_next    = rem_reg - 2'd1;
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            rem_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            rem_reg      <= rem_next;
        end
    end

    // Payload holds without reset
    always_ff @(posedge aclk) begin
        in_byte_reg   <= in_byte_next;
        in_starts_reg <= in_starts_next;
        slot_reg      <= slot_next;
    end

    assign m_valid        = (rem_reg != 2'd0);
    assign m_kind         = slot_reg[0].kind;
    assign m_offset       = slot_reg[0].offset;
    assign m_run_length   = slot_reg[0].run_length;
    assign m_fill_value   = slot_reg[0].fill_value;
    assign m_last_of_item = slot_reg[0].last_of_item;

endmodule

// ===== rtl/zrle_checker.sv =====
// ----------------------------------------------------------------------------
// zrle_checker
// Port-level checks of the loader's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module zrle_checker import zrle_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic [2:0]          m_kind,
    input logic [OFFSET_W-1:0] m_offset,
    input logic [LEN_W-1:0]    m_run_length,
    input logic [7:0]          m_fill_value,
    input logic                m_last_of_item
);

    // Hold a stalled result word unchanged
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_kind) && $stable(m_offset)
            && $stable(m_run_length) && $stable(m_fill_value)
            && $stable(m_last_of_item)))
        else $error("result word changed while stalled");

    // A status word always closes its byte and carries no run
    a_status_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_CODE && m_kind != KIND_MAP)
            |-> (m_last_of_item && m_run_length == '0 && m_offset == '0))
        else $error("malformed status word");

    // Runs cover one to 256 bytes
    a_run_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_CODE || m_kind == KIND_MAP))
            |-> (m_run_length != '0 && m_run_length <= LEN_W'(256)))
        else $error("run length out of range");

    // Bitmap runs stay inside the largest relocation bitmap
    a_map_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_MAP)
            |-> (32'(m_offset) + 32'(m_run_length) <= RELOC_BYTES_MAX))
        else $error("bitmap run beyond relocation limit");

endmodule

bind zero_rle_image_loader_decoder zrle_checker u_checker (.*);
